>>> rtl/core/gfr_pkg.sv
// shared constants and types for the gear from rpm and speed ratio block
package gfr_pkg;

  localparam int unsigned EdgeW   = 21;
  localparam int unsigned ValW    = 16;
  localparam int unsigned GearW   = 3;
  localparam int unsigned ProdW   = 23;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = EdgeW;
  localparam int unsigned DivSteps = EdgeW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [ProdW-1:0] RatioScale = ProdW'(100);
  localparam logic [ValW-1:0]  MinSpeed   = ValW'(5);

  localparam logic [GearW-1:0] GearUnknown = GearW'(0);
  localparam logic [GearW-1:0] GearFirst   = GearW'(1);
  localparam logic [GearW-1:0] GearLast    = GearW'(5);

  localparam logic [EdgeW-1:0] EdgeTopRst    = EdgeW'(16590);
  localparam logic [EdgeW-1:0] EdgeOneTwoRst = EdgeW'(11826);
  localparam logic [EdgeW-1:0] EdgeTwoThrRst = EdgeW'(8672);
  localparam logic [EdgeW-1:0] EdgeThrFouRst = EdgeW'(7211);
  localparam logic [EdgeW-1:0] EdgeFouFivRst = EdgeW'(6342);
  localparam logic [EdgeW-1:0] EdgeBotRst    = EdgeW'(5200);
  localparam logic [ValW-1:0]  MarginRst     = ValW'(400);
  localparam logic [ValW-1:0]  MinRpmRst     = ValW'(600);

  typedef enum logic [CfgIdxW-1:0] {
    REG_EDGE_TOP          = 3'd0,
    REG_EDGE_FIRST_SECOND = 3'd1,
    REG_EDGE_SECOND_THIRD = 3'd2,
    REG_EDGE_THIRD_FOURTH = 3'd3,
    REG_EDGE_FOURTH_FIFTH = 3'd4,
    REG_EDGE_BOTTOM       = 3'd5,
    REG_HYST_MARGIN       = 3'd6,
    REG_MIN_RPM           = 3'd7
  } cfg_reg_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_HYST = 6'b001000,
    ST_SCAN = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  typedef struct packed {
    logic             start;
    logic [ProdW-1:0] dividend;
    logic [ValW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [EdgeW-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/core/gfr_if.sv
// item channels of the gear from rpm and speed ratio block
interface gfr_in_if;
  logic                        valid;
  logic                        ready;
  logic [gfr_pkg::ValW-1:0]    engine_rpm;
  logic [gfr_pkg::ValW-1:0]    road_speed;

  modport source (output valid, output engine_rpm, output road_speed, input ready);
  modport sink (input valid, input engine_rpm, input road_speed, output ready);
endinterface

interface gfr_out_if;
  logic                        valid;
  logic                        ready;
  logic [gfr_pkg::GearW-1:0]   gear;

  modport source (output valid, output gear, input ready);
  modport sink (input valid, input gear, output ready);
endinterface

>>> rtl/core/gfr_div.sv
// iterative restoring divider, one quotient bit per cycle
module gfr_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gfr_pkg::div_req_t req_i,
  output gfr_pkg::div_rsp_t rsp_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [gfr_pkg::DivCntW-1:0]       cnt_q, cnt_d;
  logic [gfr_pkg::ValW-1:0]          rem_q, rem_d;
  logic [gfr_pkg::EdgeW-1:0]         quo_q, quo_d;
  logic [gfr_pkg::ValW-1:0]          dvs_q, dvs_d;
  logic [gfr_pkg::ValW:0]            trial;
  logic                              fits;

  assign trial = {rem_q, quo_q[gfr_pkg::EdgeW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      // upper dividend bits stay below the divisor for divisors of five and up
      rem_d  = gfr_pkg::ValW'(req_i.dividend[gfr_pkg::ProdW-1:gfr_pkg::EdgeW]);
      quo_d  = req_i.dividend[gfr_pkg::EdgeW-1:0];
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? gfr_pkg::ValW'(trial - {1'b0, dvs_q}) : trial[gfr_pkg::ValW-1:0];
      quo_d = {quo_q[gfr_pkg::EdgeW-2:0], fits};
      if (cnt_q == gfr_pkg::DivCntW'(gfr_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> rtl/core/gfr_band.sv
// band test with widening of both edges, lower edge clamped at zero
module gfr_band (
  input  logic [gfr_pkg::EdgeW-1:0] hi_i,
  input  logic [gfr_pkg::EdgeW-1:0] lo_i,
  input  logic [gfr_pkg::ValW-1:0]  widen_i,
  input  logic [gfr_pkg::EdgeW-1:0] ratio_i,
  output logic                      holds_o
);

  logic [gfr_pkg::EdgeW:0]   hi_w;
  logic [gfr_pkg::EdgeW-1:0] lo_w;
  logic [gfr_pkg::EdgeW-1:0] widen_x;

  assign widen_x = gfr_pkg::EdgeW'(widen_i);
  assign hi_w    = {1'b0, hi_i} + {1'b0, widen_x};
  assign lo_w    = (lo_i >= widen_x) ? (lo_i - widen_x) : '0;
  assign holds_o = (ratio_i >= lo_w) && ({1'b0, ratio_i} < hi_w);

endmodule

>>> rtl/core/gear_from_rpm_speed_ratio_core.sv
// gear estimator from engine rpm and road speed, top level
// in_if carries one engine_rpm and road_speed sample per item; out_if returns
// one gear per item (0 unknown, 1 to 5 gear number). Both use valid/ready.
// The cfg port writes the six band edges, the hysteresis margin and the
// minimum rpm by index; the user must do so only while the block is idle,
// which the block itself does not enforce. There is no read-back.
// An item with road speed below 5 or rpm below the minimum goes from idle
// straight to the result state. Otherwise the sample is registered, the
// rpm*100 product starts the divider, which forms the quotient bit by bit,
// and its done flag is registered; then band tests run through one shared
// comparator (hysteresis band of the last gear first, then gears 1 to 5 in
// order), and the result is loaded into the output register. in_if.ready
// is high only while the sequencer is idle, one item at a time.
// A finished gear waits in the output register; a new item is accepted while
// it waits, and the sequencer holds its next result until the receiver
// takes the previous one.
// Reset clears the sequencer, the output valid and the last gear (unknown),
// and restores all configuration registers to their default values.
module gear_from_rpm_speed_ratio_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  gfr_in_if.sink                      in_if,
  gfr_out_if.source                   out_if,
  input  logic                        cfg_we_i,
  input  logic [gfr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [gfr_pkg::CfgW-1:0]    cfg_wdata_i
);

  gfr_pkg::state_e               state_q, state_d;
  logic [gfr_pkg::EdgeW-1:0]     edge_top_q, edge_12_q, edge_23_q, edge_34_q, edge_45_q;
  logic [gfr_pkg::EdgeW-1:0]     edge_bot_q;
  logic [gfr_pkg::ValW-1:0]      margin_q, min_rpm_q;
  logic [gfr_pkg::ValW-1:0]      rpm_q, rpm_d, spd_q, spd_d;
  logic [gfr_pkg::EdgeW-1:0]     ratio_q, ratio_d;
  logic [gfr_pkg::GearW-1:0]     last_gear_q, last_gear_d;
  logic [gfr_pkg::GearW-1:0]     res_q, res_d;
  logic [gfr_pkg::GearW-1:0]     scan_q, scan_d;
  logic                          out_valid_q, out_valid_d;
  logic [gfr_pkg::GearW-1:0]     out_gear_q, out_gear_d;
  logic                          in_acc;
  logic                          out_load;
  logic [gfr_pkg::GearW-1:0]     band_gear;
  logic [gfr_pkg::ValW-1:0]      band_widen;
  logic [gfr_pkg::EdgeW-1:0]     band_hi, band_lo;
  logic                          band_holds;
  gfr_pkg::div_req_t             div_req;
  gfr_pkg::div_rsp_t             div_rsp;

  assign in_if.ready = (state_q == gfr_pkg::ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_load    = (state_q == gfr_pkg::ST_DONE) && (!out_valid_q || out_if.ready);

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_top_q <= gfr_pkg::EdgeTopRst;
      edge_12_q  <= gfr_pkg::EdgeOneTwoRst;
      edge_23_q  <= gfr_pkg::EdgeTwoThrRst;
      edge_34_q  <= gfr_pkg::EdgeThrFouRst;
      edge_45_q  <= gfr_pkg::EdgeFouFivRst;
      edge_bot_q <= gfr_pkg::EdgeBotRst;
      margin_q   <= gfr_pkg::MarginRst;
      min_rpm_q  <= gfr_pkg::MinRpmRst;
    end else if (cfg_we_i) begin
      case (gfr_pkg::cfg_reg_e'(cfg_idx_i))
        gfr_pkg::REG_EDGE_TOP:          edge_top_q <= cfg_wdata_i;
        gfr_pkg::REG_EDGE_FIRST_SECOND: edge_12_q  <= cfg_wdata_i;
        gfr_pkg::REG_EDGE_SECOND_THIRD: edge_23_q  <= cfg_wdata_i;
        gfr_pkg::REG_EDGE_THIRD_FOURTH: edge_34_q  <= cfg_wdata_i;
        gfr_pkg::REG_EDGE_FOURTH_FIFTH: edge_45_q  <= cfg_wdata_i;
        gfr_pkg::REG_EDGE_BOTTOM:       edge_bot_q <= cfg_wdata_i;
        gfr_pkg::REG_HYST_MARGIN:       margin_q   <= cfg_wdata_i[gfr_pkg::ValW-1:0];
        gfr_pkg::REG_MIN_RPM:           min_rpm_q  <= cfg_wdata_i[gfr_pkg::ValW-1:0];
        default: ;
      endcase
    end
  end

  // edges of the band under test
  always_comb begin
    case (band_gear)
      3'd1:    begin band_hi = edge_top_q; band_lo = edge_12_q;  end
      3'd2:    begin band_hi = edge_12_q;  band_lo = edge_23_q;  end
      3'd3:    begin band_hi = edge_23_q;  band_lo = edge_34_q;  end
      3'd4:    begin band_hi = edge_34_q;  band_lo = edge_45_q;  end
      3'd5:    begin band_hi = edge_45_q;  band_lo = edge_bot_q; end
      default: begin band_hi = '0;         band_lo = '0;         end
    endcase
  end

  assign band_gear  = (state_q == gfr_pkg::ST_HYST) ? last_gear_q : scan_q;
  assign band_widen = (state_q == gfr_pkg::ST_HYST) ? margin_q : '0;

  gfr_band u_band (
    .hi_i    (band_hi),
    .lo_i    (band_lo),
    .widen_i (band_widen),
    .ratio_i (ratio_q),
    .holds_o (band_holds)
  );

  assign div_req.start    = (state_q == gfr_pkg::ST_MUL);
  assign div_req.dividend = gfr_pkg::ProdW'(rpm_q) * gfr_pkg::RatioScale;
  assign div_req.divisor  = spd_q;

  gfr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    rpm_d       = rpm_q;
    spd_d       = spd_q;
    ratio_d     = ratio_q;
    res_d       = res_q;
    scan_d      = scan_q;
    last_gear_d = last_gear_q;
    out_valid_d = out_valid_q;
    out_gear_d  = out_gear_q;
    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      gfr_pkg::ST_IDLE: begin
        if (in_acc) begin
          rpm_d = in_if.engine_rpm;
          spd_d = in_if.road_speed;
          if ((in_if.road_speed < gfr_pkg::MinSpeed) || (in_if.engine_rpm < min_rpm_q)) begin
            res_d   = gfr_pkg::GearUnknown;
            state_d = gfr_pkg::ST_DONE;
          end else begin
            state_d = gfr_pkg::ST_MUL;
          end
        end
      end
      gfr_pkg::ST_MUL: begin
        state_d = gfr_pkg::ST_DIV;
      end
      gfr_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          ratio_d = div_rsp.quotient;
          scan_d  = gfr_pkg::GearFirst;
          if (last_gear_q inside {[gfr_pkg::GearFirst:gfr_pkg::GearLast]}) begin
            state_d = gfr_pkg::ST_HYST;
          end else begin
            state_d = gfr_pkg::ST_SCAN;
          end
        end
      end
      gfr_pkg::ST_HYST: begin
        if (band_holds) begin
          res_d   = last_gear_q;
          state_d = gfr_pkg::ST_DONE;
        end else begin
          state_d = gfr_pkg::ST_SCAN;
        end
      end
      gfr_pkg::ST_SCAN: begin
        if (band_holds) begin
          res_d   = scan_q;
          state_d = gfr_pkg::ST_DONE;
        end else if (scan_q == gfr_pkg::GearLast) begin
          res_d   = gfr_pkg::GearUnknown;
          state_d = gfr_pkg::ST_DONE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      gfr_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_gear_d  = res_q;
          last_gear_d = res_q;
          state_d     = gfr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gfr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gfr_pkg::ST_IDLE;
      last_gear_q <= gfr_pkg::GearUnknown;
      out_valid_q <= 1'b0;
      scan_q      <= gfr_pkg::GearFirst;
    end else begin
      state_q     <= state_d;
      last_gear_q <= last_gear_d;
      out_valid_q <= out_valid_d;
      scan_q      <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rpm_q      <= rpm_d;
    spd_q      <= spd_d;
    ratio_q    <= ratio_d;
    res_q      <= res_d;
    out_gear_q <= out_gear_d;
  end

  assign out_if.valid = out_valid_q;
  assign out_if.gear  = out_gear_q;

endmodule

>>> rtl/core/gfr_checker.sv
// port checker for the gear estimator, bound to the top level
module gfr_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [gfr_pkg::GearW-1:0] out_gear_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_gear_i))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_gear_i <= gfr_pkg::GearLast))
    else $error("gear out of range");

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item accepted while busy");

  // returning to idle always comes with a result in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_i) |-> out_valid_i)
    else $error("idle without a result");

endmodule

bind gear_from_rpm_speed_ratio_core gfr_checker u_gfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_gear_i  (out_if.gear)
);

>>> tb/gear_from_rpm_speed_ratio_core_tb.sv
// self-checking testbench for the gear from rpm and speed ratio block
module gear_from_rpm_speed_ratio_core_tb;

  localparam int unsigned DrainCycles = 8;
  localparam int unsigned EndSettle   = 40;
  localparam int unsigned LongHold    = 400;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  gfr_pkg::cfg_reg_e cfg_idx;
  logic [gfr_pkg::CfgW-1:0] cfg_wdata;

  gfr_in_if  in_ch ();
  gfr_out_if out_ch ();

  gear_from_rpm_speed_ratio_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #10 clk_i = ~clk_i;

  logic [gfr_pkg::CfgW-1:0]  cal_regs [8];
  logic [gfr_pkg::GearW-1:0] held_gear;
  logic [gfr_pkg::GearW-1:0] gear_queue [$];
  longint                    drift_ratio;
  int                        mismatch_count;
  int                        hold_cycles;
  bit                        idle_on;

  function automatic logic in_band(input int unsigned g,
                                   input logic [gfr_pkg::ProdW-1:0] ratio,
                                   input logic [gfr_pkg::ValW-1:0] widen);
    logic [gfr_pkg::ProdW-1:0] lo;
    logic [gfr_pkg::ProdW-1:0] hi;
    hi = gfr_pkg::ProdW'(cal_regs[g-1]) + gfr_pkg::ProdW'(widen);
    lo = (cal_regs[g] >= gfr_pkg::CfgW'(widen)) ?
         gfr_pkg::ProdW'(cal_regs[g]) - gfr_pkg::ProdW'(widen) : '0;
    return ratio >= lo && ratio < hi;
  endfunction

  function automatic logic [gfr_pkg::GearW-1:0] gear_for_sample(
      input logic [gfr_pkg::ValW-1:0] rpm, input logic [gfr_pkg::ValW-1:0] spd);
    logic [gfr_pkg::ProdW-1:0] ratio;
    logic [gfr_pkg::GearW-1:0] g;
    g = gfr_pkg::GearUnknown;
    if (spd >= gfr_pkg::MinSpeed &&
        rpm >= cal_regs[gfr_pkg::REG_MIN_RPM][gfr_pkg::ValW-1:0]) begin
      ratio = (gfr_pkg::ProdW'(rpm) * gfr_pkg::RatioScale) / gfr_pkg::ProdW'(spd);
      if (held_gear >= gfr_pkg::GearFirst && held_gear <= gfr_pkg::GearLast &&
          in_band(held_gear, ratio,
                  cal_regs[gfr_pkg::REG_HYST_MARGIN][gfr_pkg::ValW-1:0])) begin
        g = held_gear;
      end else begin
        for (int k = gfr_pkg::GearFirst; k <= gfr_pkg::GearLast; k++) begin
          if (g == gfr_pkg::GearUnknown && in_band(k, ratio, '0)) g = gfr_pkg::GearW'(k);
        end
      end
    end
    return g;
  endfunction

  // receiver: long hold-off on request, otherwise random stall bursts while idle_on is set
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_gear
    logic [gfr_pkg::GearW-1:0] want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (gear_queue.size() == 0) begin
        $display("%0t: unexpected gear item, expected none, actual %0d", $time, out_ch.gear);
        mismatch_count++;
      end else begin
        want = gear_queue.pop_front();
        if (out_ch.gear !== want) begin
          $display("%0t: gear mismatch, expected %0d, actual %0d", $time, want, out_ch.gear);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_sample(input logic [gfr_pkg::ValW-1:0] rpm,
                             input logic [gfr_pkg::ValW-1:0] spd);
    logic [gfr_pkg::GearW-1:0] want;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.engine_rpm <= rpm;
    in_ch.road_speed <= spd;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    want = gear_for_sample(rpm, spd);
    held_gear = want;
    gear_queue.push_back(want);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (gear_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic load_calibration(input logic [gfr_pkg::CfgW-1:0] top,
                                  input logic [gfr_pkg::CfgW-1:0] e12,
                                  input logic [gfr_pkg::CfgW-1:0] e23,
                                  input logic [gfr_pkg::CfgW-1:0] e34,
                                  input logic [gfr_pkg::CfgW-1:0] e45,
                                  input logic [gfr_pkg::CfgW-1:0] bot,
                                  input logic [gfr_pkg::CfgW-1:0] margin,
                                  input logic [gfr_pkg::CfgW-1:0] min_rpm);
    logic [gfr_pkg::CfgW-1:0] vals [8];
    vals[gfr_pkg::REG_EDGE_TOP]          = top;
    vals[gfr_pkg::REG_EDGE_FIRST_SECOND] = e12;
    vals[gfr_pkg::REG_EDGE_SECOND_THIRD] = e23;
    vals[gfr_pkg::REG_EDGE_THIRD_FOURTH] = e34;
    vals[gfr_pkg::REG_EDGE_FOURTH_FIFTH] = e45;
    vals[gfr_pkg::REG_EDGE_BOTTOM]       = bot;
    vals[gfr_pkg::REG_HYST_MARGIN]       = margin;
    vals[gfr_pkg::REG_MIN_RPM]           = min_rpm;
    for (int k = 0; k < 8; k++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= gfr_pkg::cfg_reg_e'(k);
      cfg_wdata <= vals[k];
      @(posedge clk_i);
      cal_regs[k] = (k >= gfr_pkg::REG_HYST_MARGIN) ?
                    gfr_pkg::CfgW'(vals[k][gfr_pkg::ValW-1:0]) : vals[k];
    end
    cfg_we <= 1'b0;
    @(posedge clk_i);
    drift_ratio = longint'(cal_regs[gfr_pkg::REG_EDGE_FOURTH_FIFTH]);
  endtask

  // mostly ratios drifting around the band edges, some noise and rejected samples
  task automatic pick_sample(output logic [gfr_pkg::ValW-1:0] rpm,
                             output logic [gfr_pkg::ValW-1:0] spd);
    longint m;
    longint rpm_l;
    longint min_l;
    longint sp;
    min_l = longint'(cal_regs[gfr_pkg::REG_MIN_RPM]);
    m = longint'(cal_regs[gfr_pkg::REG_HYST_MARGIN]) + 2;
    case ($urandom_range(0, 9))
      0: begin
        rpm = $urandom_range(0, 65535);
        spd = $urandom_range(0, 65535);
      end
      1: begin
        rpm = $urandom_range(0, 65535);
        spd = $urandom_range(0, 4);
      end
      2: begin
        rpm = (min_l > 0) ? gfr_pkg::ValW'($urandom_range(0, int'(min_l - 1))) :
                            gfr_pkg::ValW'($urandom);
        spd = $urandom_range(5, 200);
      end
      default: begin
        if ($urandom_range(0, 7) == 0)
          drift_ratio = longint'(cal_regs[$urandom_range(0, 5)]) +
                        longint'($urandom_range(0, int'(2 * m))) - m;
        else
          drift_ratio = drift_ratio + longint'($urandom_range(0, int'(m))) - m / 2;
        if (drift_ratio < 0) drift_ratio = 0;
        sp = longint'($urandom_range(5, 120));
        rpm_l = drift_ratio * sp / 100;
        if (rpm_l > 65535) begin
          sp = 5;
          rpm_l = drift_ratio * sp / 100;
          if (rpm_l > 65535) rpm_l = 65535;
        end
        if (rpm_l < min_l) rpm_l = min_l;
        rpm = gfr_pkg::ValW'(rpm_l);
        spd = gfr_pkg::ValW'(sp);
      end
    endcase
  endtask

  task automatic run_random(input int count);
    logic [gfr_pkg::ValW-1:0] rpm;
    logic [gfr_pkg::ValW-1:0] spd;
    repeat (count) begin
      pick_sample(rpm, spd);
      send_sample(rpm, spd);
    end
  endtask

  task automatic test_directed_defaults();
    idle_on = 1'b0;
    send_sample(16'd0, 16'd0);
    send_sample(16'd65535, 16'd4);
    send_sample(16'd599, 16'd5);
    send_sample(16'd600, 16'd5);
    send_sample(16'd65535, 16'd5);
    send_sample(16'd65535, 16'd65535);
    send_sample(16'd0, 16'd65535);
    send_sample(16'd3000, 16'd30);
    send_sample(16'd3000, 16'd25);
    send_sample(16'd3000, 16'd24);
    send_sample(16'd2300, 16'd20);
    send_sample(16'd2280, 16'd20);
    send_sample(16'd4000, 16'd50);
    send_sample(16'd3500, 16'd50);
    send_sample(16'd3000, 16'd50);
    send_sample(16'd2500, 16'd50);
    send_sample(16'd2350, 16'd50);
    send_sample(16'd1659, 16'd10);
    send_sample(16'd1670, 16'd10);
    send_sample(16'd5200, 16'd100);
    send_sample(16'd1658, 16'd10);
    send_sample(16'd1670, 16'd10);
    drain_results();
  endtask

  task automatic test_random_default_cfg();
    idle_on = 1'b1;
    drift_ratio = longint'(cal_regs[gfr_pkg::REG_EDGE_FOURTH_FIFTH]);
    run_random(150);
    drain_results();
  endtask

  task automatic test_cfg_extremes();
    idle_on = 1'b1;
    load_calibration('0, '0, '0, '0, '0, '0, '0, '0);
    run_random(30);
    drain_results();
    load_calibration('1, '1, '1, '1, '1, '1, '1, '1);
    send_sample(16'd65535, 16'd5);
    send_sample(16'd65534, 16'd5);
    run_random(28);
    drain_results();
    load_calibration('1, 21'd1500000, 21'd100000, 21'd20000, 21'd5000, '0,
                     21'h1F_FFFF, 21'h1F_0000);
    run_random(30);
    drain_results();
  endtask

  task automatic test_random_configs();
    logic [gfr_pkg::CfgW-1:0] e [6];
    logic [gfr_pkg::CfgW-1:0] step;
    for (int p = 0; p < 4; p++) begin
      idle_on = (p != 2);
      step = (p == 3) ? gfr_pkg::CfgW'(200000) : gfr_pkg::CfgW'(6000);
      e[5] = (p == 3) ? gfr_pkg::CfgW'($urandom_range(0, 500000)) :
                        gfr_pkg::CfgW'($urandom_range(0, 20000));
      for (int k = 4; k >= 0; k--)
        e[k] = e[k+1] + gfr_pkg::CfgW'($urandom_range(0, int'(step)));
      load_calibration(e[0], e[1], e[2], e[3], e[4], e[5],
                       gfr_pkg::CfgW'($urandom_range(0, 3000)),
                       gfr_pkg::CfgW'($urandom_range(0, 2000)));
      run_random(100);
      drain_results();
    end
    idle_on = 1'b1;
    load_calibration(gfr_pkg::CfgW'($urandom_range(0, 20000)),
                     gfr_pkg::CfgW'($urandom_range(0, 20000)),
                     gfr_pkg::CfgW'($urandom_range(0, 20000)),
                     gfr_pkg::CfgW'($urandom_range(0, 20000)),
                     gfr_pkg::CfgW'($urandom_range(0, 20000)),
                     gfr_pkg::CfgW'($urandom_range(0, 20000)),
                     gfr_pkg::CfgW'($urandom_range(0, 1000)),
                     gfr_pkg::CfgW'($urandom_range(0, 1000)));
    run_random(60);
    drain_results();
  endtask

  task automatic test_output_backpressure();
    idle_on = 1'b1;
    load_calibration(gfr_pkg::EdgeTopRst, gfr_pkg::EdgeOneTwoRst, gfr_pkg::EdgeTwoThrRst,
                     gfr_pkg::EdgeThrFouRst, gfr_pkg::EdgeFouFivRst, gfr_pkg::EdgeBotRst,
                     gfr_pkg::CfgW'(gfr_pkg::MarginRst), gfr_pkg::CfgW'(gfr_pkg::MinRpmRst));
    hold_cycles = LongHold;
    run_random(50);
    drain_results();
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    load_calibration(21'd30000, 21'd20000, 21'd12000, 21'd8000, 21'd5500, 21'd3000,
                     21'd800, 21'd0);
    run_random(130);
    drain_results();
  endtask

  initial begin
    rst_ni           <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.engine_rpm <= '0;
    in_ch.road_speed <= '0;
    cfg_we           <= 1'b0;
    cfg_idx          <= gfr_pkg::REG_EDGE_TOP;
    cfg_wdata        <= '0;
    idle_on          = 1'b0;
    hold_cycles      = 0;
    mismatch_count   = 0;
    held_gear        = gfr_pkg::GearUnknown;
    cal_regs[gfr_pkg::REG_EDGE_TOP]          = gfr_pkg::EdgeTopRst;
    cal_regs[gfr_pkg::REG_EDGE_FIRST_SECOND] = gfr_pkg::EdgeOneTwoRst;
    cal_regs[gfr_pkg::REG_EDGE_SECOND_THIRD] = gfr_pkg::EdgeTwoThrRst;
    cal_regs[gfr_pkg::REG_EDGE_THIRD_FOURTH] = gfr_pkg::EdgeThrFouRst;
    cal_regs[gfr_pkg::REG_EDGE_FOURTH_FIFTH] = gfr_pkg::EdgeFouFivRst;
    cal_regs[gfr_pkg::REG_EDGE_BOTTOM]       = gfr_pkg::EdgeBotRst;
    cal_regs[gfr_pkg::REG_HYST_MARGIN]       = gfr_pkg::CfgW'(gfr_pkg::MarginRst);
    cal_regs[gfr_pkg::REG_MIN_RPM]           = gfr_pkg::CfgW'(gfr_pkg::MinRpmRst);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_defaults();
    test_random_default_cfg();
    test_cfg_extremes();
    test_random_configs();
    test_output_backpressure();
    test_no_idle();

    repeat (EndSettle) @(posedge clk_i);
    if (mismatch_count == 0 && gear_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/gfr_pkg.sv
rtl/core/gfr_if.sv
rtl/core/gfr_div.sv
rtl/core/gfr_band.sv
rtl/core/gear_from_rpm_speed_ratio_core.sv
rtl/core/gfr_checker.sv
tb/gear_from_rpm_speed_ratio_core_tb.sv
